/* rtl/ted_pkg.sv */
package ted_pkg;

    // Default sizes
    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Byte values of interest
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] SJIS_LO  = 8'h81;
    localparam logic [7:0] SJIS_HI  = 8'h9F;
    localparam logic [7:0] EUC_LO   = 8'hA1;
    localparam logic [7:0] EUC_HI   = 8'hDF;
    localparam logic [7:0] BYTE_FE  = 8'hFE;
    localparam logic [7:0] BYTE_FF  = 8'hFF;

    // Ratio used by the NUL and lead-byte tests
    localparam int RATIO = 10;

    // Byte-order mark kinds
    localparam logic [1:0] BOM_NONE = 2'd0;
    localparam logic [1:0] BOM_LE   = 2'd1;
    localparam logic [1:0] BOM_BE   = 2'd2;

    // Encoding codes
    localparam logic [3:0] ENC_EMPTY  = 4'd0;
    localparam logic [3:0] ENC_UCS2LE = 4'd1;
    localparam logic [3:0] ENC_UCS2BE = 4'd2;
    localparam logic [3:0] ENC_JIS    = 4'd3;
    localparam logic [3:0] ENC_ASCII  = 4'd4;
    localparam logic [3:0] ENC_UTF8   = 4'd5;
    localparam logic [3:0] ENC_SJIS   = 4'd6;
    localparam logic [3:0] ENC_EUC    = 4'd7;
    localparam logic [3:0] ENC_BINARY = 4'd8;

    // Slots of the counter snapshot
    localparam int CNT_EUC      = 0;
    localparam int CNT_HIGH     = 1;
    localparam int CNT_SJIS     = 2;
    localparam int CNT_NUL_ODD  = 3;
    localparam int CNT_NUL_EVEN = 4;
    localparam int CNT_NUM      = 5;

    // Narrow facts about one finished file
    typedef struct packed {
        logic       empty;
        logic       odd;
        logic [1:0] bom;
        logic       esc_any;
        logic       utf8_ok;
    } t_flags;

    // Facts plus the results of the counter comparisons
    typedef struct packed {
        t_flags f;
        logic   le_nul;
        logic   be_nul;
        logic   high_zero;
        logic   sjis_ok;
        logic   euc_ok;
    } t_cls;

endpackage

/* rtl/ted_front.sv */
module ted_front
    import ted_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_has_byte,
    input  logic                            i_last,
    input  logic                            i_q_full,
    output logic                            o_push,
    output t_flags                          o_flags,
    output logic [CNT_NUM*COUNT_BITS-1:0]   o_counts
);

    logic [COUNT_BITS-1:0] r_nul_even, r_nul_odd, r_esc, r_sjis, r_high, r_euc, r_u8_seq;
    logic [COUNT_BITS-1:0] n_nul_even, n_nul_odd, n_esc, n_sjis, n_high, n_euc, n_u8_seq;
    logic [2:0] r_u8_pend, n_u8_pend;
    logic       r_u8_bad, n_u8_bad;
    logic       r_odd, n_odd;
    logic [1:0] r_seen, n_seen;
    logic [7:0] r_first, n_first;
    logic [1:0] r_bom, n_bom;
    logic       accept;
    logic [7:0] b;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    assign b          = i_data_byte;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && i_last;

    // Fold the incoming byte into the statistics
    always_comb begin
        n_nul_even = r_nul_even;
        n_nul_odd  = r_nul_odd;
        n_esc      = r_esc;
        n_sjis     = r_sjis;
        n_high     = r_high;
        n_euc      = r_euc;
        n_u8_seq   = r_u8_seq;
        n_u8_pend  = r_u8_pend;
        n_u8_bad   = r_u8_bad;
        n_odd      = r_odd;
        n_seen     = r_seen;
        n_first    = r_first;
        n_bom      = r_bom;
        if (i_has_byte) begin
            if (b == BYTE_NUL) begin
                if (r_odd) n_nul_odd = sat_inc(r_nul_odd);
                else       n_nul_even = sat_inc(r_nul_even);
            end
            if (b == BYTE_ESC) n_esc = sat_inc(r_esc);
            if (b >= SJIS_LO && b <= SJIS_HI) n_sjis = sat_inc(r_sjis);
            if (b[7]) n_high = sat_inc(r_high);
            if (b >= EUC_LO && b <= EUC_HI) n_euc = sat_inc(r_euc);

            // UTF-8 sequence checker
            if (!r_u8_bad) begin
                if (b == BYTE_FE || b == BYTE_FF) begin
                    n_u8_bad = 1'b1;
                end else if (r_u8_pend != 3'd0) begin
                    if (b[7:6] == 2'b10) begin
                        n_u8_pend = r_u8_pend - 3'd1;
                        if (r_u8_pend == 3'd1) n_u8_seq = sat_inc(r_u8_seq);
                    end else begin
                        n_u8_bad = 1'b1;
                    end
                end else if (b[7:6] == 2'b10) begin
                    n_u8_bad = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    n_u8_pend = 3'd1;
                end else if (b[7:4] == 4'b1110) begin
                    n_u8_pend = 3'd2;
                end else if (b[7:3] == 5'b11110) begin
                    n_u8_pend = 3'd3;
                end else if (b[7:2] == 6'b111110) begin
                    n_u8_pend = 3'd4;
                end else if (b[7:1] == 7'b1111110) begin
                    n_u8_pend = 3'd5;
                end
            end

            // Byte-order mark from the first two bytes
            if (r_seen == 2'd0) begin
                n_first = b;
            end else if (r_seen == 2'd1) begin
                if (r_first == BYTE_FF && b == BYTE_FE)      n_bom = BOM_LE;
                else if (r_first == BYTE_FE && b == BYTE_FF) n_bom = BOM_BE;
            end
            if (r_seen != 2'd2) n_seen = r_seen + 2'd1;
            n_odd = !r_odd;
        end
    end

    // Snapshot handed to the queue on the last item
    always_comb begin
        o_flags.empty   = (n_seen == 2'd0);
        o_flags.odd     = n_odd;
        o_flags.bom     = n_bom;
        o_flags.esc_any = (n_esc != '0);
        o_flags.utf8_ok = !n_u8_bad && (n_u8_pend == 3'd0) && (n_u8_seq != '0);
        o_counts = '0;
        o_counts[CNT_EUC*COUNT_BITS      +: COUNT_BITS] = n_euc;
        o_counts[CNT_HIGH*COUNT_BITS     +: COUNT_BITS] = n_high;
        o_counts[CNT_SJIS*COUNT_BITS     +: COUNT_BITS] = n_sjis;
        o_counts[CNT_NUL_ODD*COUNT_BITS  +: COUNT_BITS] = n_nul_odd;
        o_counts[CNT_NUL_EVEN*COUNT_BITS +: COUNT_BITS] = n_nul_even;
    end

    // Advance on each item, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_nul_even <= '0;
            r_nul_odd  <= '0;
            r_esc      <= '0;
            r_sjis     <= '0;
            r_high     <= '0;
            r_euc      <= '0;
            r_u8_seq   <= '0;
            r_u8_pend  <= 3'd0;
            r_u8_bad   <= 1'b0;
            r_odd      <= 1'b0;
            r_seen     <= 2'd0;
            r_first    <= 8'd0;
            r_bom      <= BOM_NONE;
        end else if (accept) begin
            r_nul_even <= n_nul_even;
            r_nul_odd  <= n_nul_odd;
            r_esc      <= n_esc;
            r_sjis     <= n_sjis;
            r_high     <= n_high;
            r_euc      <= n_euc;
            r_u8_seq   <= n_u8_seq;
            r_u8_pend  <= n_u8_pend;
            r_u8_bad   <= n_u8_bad;
            r_odd      <= n_odd;
            r_seen     <= n_seen;
            r_first    <= n_first;
            r_bom      <= n_bom;
        end
    end

endmodule

/* rtl/ted_queue.sv */
module ted_queue
    import ted_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Store an entry
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_wdata;
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= wrap_inc(r_wptr);
            if (do_pop)  r_rptr <= wrap_inc(r_rptr);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

endmodule

/* rtl/ted_back.sv */
module ted_back
    import ted_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  t_flags                          i_flags,
    input  logic [CNT_NUM*COUNT_BITS-1:0]   i_counts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [3:0]                      o_encoding
);

    localparam int XW = COUNT_BITS + 4;

    logic [COUNT_BITS-1:0] c_even, c_odd, c_sjis, c_high, c_euc;
    logic [XW-1:0]         x_even, x_odd, x_sjis, x_high, even_t10, odd_t10, sjis_t10;
    t_cls                  cls;
    t_cls                  r_s1;
    logic                  r_s1_valid;
    logic                  r_out_valid;
    logic [3:0]            r_enc, n_enc;
    logic                  out_free, s1_free;

    assign c_even = i_counts[CNT_NUL_EVEN*COUNT_BITS +: COUNT_BITS];
    assign c_odd  = i_counts[CNT_NUL_ODD*COUNT_BITS  +: COUNT_BITS];
    assign c_sjis = i_counts[CNT_SJIS*COUNT_BITS     +: COUNT_BITS];
    assign c_high = i_counts[CNT_HIGH*COUNT_BITS     +: COUNT_BITS];
    assign c_euc  = i_counts[CNT_EUC*COUNT_BITS      +: COUNT_BITS];

    // Compare against ten times a count plus ten, in place of a division
    always_comb begin
        x_even   = XW'(c_even);
        x_odd    = XW'(c_odd);
        x_sjis   = XW'(c_sjis);
        x_high   = XW'(c_high);
        even_t10 = (x_even << 3) + (x_even << 1) + XW'(RATIO);
        odd_t10  = (x_odd << 3) + (x_odd << 1) + XW'(RATIO);
        sjis_t10 = (x_sjis << 3) + (x_sjis << 1) + XW'(RATIO);
        cls.f         = i_flags;
        cls.le_nul    = (even_t10 <= x_odd);
        cls.be_nul    = (x_even >= odd_t10);
        cls.high_zero = (c_high == '0);
        cls.sjis_ok   = (sjis_t10 > x_high);
        cls.euc_ok    = ((c_high >> 1) < c_euc);
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_free     = !r_s1_valid || out_free;
    assign o_q_pop     = i_q_valid && s1_free;
    assign o_out_valid = r_out_valid;
    assign o_encoding  = r_enc;

    // Pick the verdict from the registered comparisons
    always_comb begin
        if (r_s1.f.empty) begin
            n_enc = ENC_EMPTY;
        end else if (!r_s1.f.odd && (r_s1.f.bom == BOM_LE
                     || (r_s1.f.bom != BOM_BE && r_s1.le_nul))) begin
            n_enc = ENC_UCS2LE;
        end else if (!r_s1.f.odd && (r_s1.f.bom == BOM_BE
                     || (r_s1.f.bom != BOM_LE && r_s1.be_nul))) begin
            n_enc = ENC_UCS2BE;
        end else if (r_s1.high_zero) begin
            n_enc = r_s1.f.esc_any ? ENC_JIS : ENC_ASCII;
        end else if (r_s1.f.utf8_ok) begin
            n_enc = ENC_UTF8;
        end else if (r_s1.sjis_ok) begin
            n_enc = ENC_SJIS;
        end else if (r_s1.euc_ok) begin
            n_enc = ENC_EUC;
        end else begin
            n_enc = ENC_BINARY;
        end
    end

    // Hold the comparison stage and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free)  r_s1_valid  <= i_q_valid;
            if (out_free) r_out_valid <= r_s1_valid;
        end
        if (o_q_pop)              r_s1  <= cls;
        if (out_free && r_s1_valid) r_enc <= n_enc;
    end

endmodule

/* rtl/text_encoding_detector_unit.sv */
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_data_byte, i_has_byte, i_last
// output    o_out_valid / i_out_ready   o_encoding
//
// One item is taken every cycle while the queue is not full; the byte statistics
// are registered as each item is taken. A verdict passes from the edge that takes
// its last item through the queue write, comparison stage and output register,
// and verdicts stream at one a cycle while i_out_ready is held high.
// Reset is synchronous, active low, and clears all counters and the queue.
// A full queue drops o_in_ready; the back end stalls only on i_out_ready.
module text_encoding_detector_unit
    import ted_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_encoding
);

    localparam int CW = CNT_NUM * COUNT_BITS;
    localparam int FW = $bits(t_flags);
    localparam int QW = FW + CW;

    logic          push, q_full, q_valid, q_pop;
    t_flags        f_flags, b_flags;
    logic [CW-1:0] f_counts;
    logic [QW-1:0] q_rdata;

    // Count bytes and snapshot the statistics
    ted_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_flags     (f_flags),
        .o_counts    (f_counts)
    );

    // Buffer finished files between the two sides
    ted_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_flags, f_counts}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign b_flags = t_flags'(q_rdata[QW-1 -: FW]);

    // Decide the encoding
    ted_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_flags     (b_flags),
        .i_counts    (q_rdata[CW-1:0]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_encoding  (o_encoding)
    );

endmodule

/* tb/sv/ted_verdict_checker.sv */
`timescale 1ns / 1ps

module ted_verdict_checker
    import ted_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] i_encoding,
    output int         o_fail_count,
    output int         o_pending
);

    // Running statistics of the file in flight
    typedef struct packed {
        logic [COUNT_BITS-1:0] nul_even;
        logic [COUNT_BITS-1:0] nul_odd;
        logic [COUNT_BITS-1:0] esc_cnt;
        logic [COUNT_BITS-1:0] lead_cnt;
        logic [COUNT_BITS-1:0] high_cnt;
        logic [COUNT_BITS-1:0] euc_cnt;
        logic [COUNT_BITS-1:0] utf8_done;
        logic [2:0]            utf8_left;
        logic                  utf8_bad;
        logic                  odd;
        logic [1:0]            seen;
        logic [7:0]            first;
        logic [1:0]            bom;
    } t_file_stats;

    t_file_stats stats = '0;
    logic [3:0]  verdict_q[$];
    int          fails = 0;

    // Saturating increment
    function automatic logic [COUNT_BITS-1:0] sat_bump(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

    // Fold one byte into the file statistics
    function automatic t_file_stats fold_byte(input t_file_stats s, input logic [7:0] b);
        if (b == BYTE_NUL) begin
            if (s.odd) s.nul_odd = sat_bump(s.nul_odd);
            else s.nul_even = sat_bump(s.nul_even);
        end
        if (b == BYTE_ESC) s.esc_cnt = sat_bump(s.esc_cnt);
        if (b >= SJIS_LO && b <= SJIS_HI) s.lead_cnt = sat_bump(s.lead_cnt);
        if (b[7]) s.high_cnt = sat_bump(s.high_cnt);
        if (b >= EUC_LO && b <= EUC_HI) s.euc_cnt = sat_bump(s.euc_cnt);

        // UTF-8 checker: once broken it stays broken
        if (!s.utf8_bad) begin
            if (b == BYTE_FE || b == BYTE_FF) begin
                s.utf8_bad = 1'b1;
            end else if (s.utf8_left != 3'd0) begin
                if (b[7:6] == 2'b10) begin
                    s.utf8_left = s.utf8_left - 3'd1;
                    if (s.utf8_left == 3'd0) s.utf8_done = sat_bump(s.utf8_done);
                end else begin
                    s.utf8_bad = 1'b1;
                end
            end else if (b[7:6] == 2'b10) begin
                s.utf8_bad = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                s.utf8_left = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
                s.utf8_left = 3'd2;
            end else if (b[7:3] == 5'b11110) begin
                s.utf8_left = 3'd3;
            end else if (b[7:2] == 6'b111110) begin
                s.utf8_left = 3'd4;
            end else if (b[7:1] == 7'b1111110) begin
                s.utf8_left = 3'd5;
            end
        end

        // Byte-order mark from the first two bytes
        if (s.seen == 2'd0) begin
            s.first = b;
        end else if (s.seen == 2'd1) begin
            if (s.first == BYTE_FF && b == BYTE_FE) s.bom = BOM_LE;
            else if (s.first == BYTE_FE && b == BYTE_FF) s.bom = BOM_BE;
        end
        if (s.seen < 2'd2) s.seen = s.seen + 2'd1;
        s.odd = !s.odd;
        return s;
    endfunction

    // Decide the encoding of a finished file
    function automatic logic [3:0] judge_file(input t_file_stats s);
        logic le;
        logic be;
        le = (s.bom == BOM_LE);
        be = (s.bom == BOM_BE);
        if (s.seen == 2'd0) return ENC_EMPTY;
        if (!s.odd) begin
            if (le || (!be && s.nul_even < s.nul_odd / RATIO)) return ENC_UCS2LE;
            if (be || (!le && s.nul_even / RATIO > s.nul_odd)) return ENC_UCS2BE;
        end
        if (s.high_cnt == '0) return (s.esc_cnt != '0) ? ENC_JIS : ENC_ASCII;
        if (!s.utf8_bad && s.utf8_left == 3'd0 && s.utf8_done != '0) return ENC_UTF8;
        if (s.lead_cnt >= s.high_cnt / RATIO) return ENC_SJIS;
        if (s.high_cnt / 2 < s.euc_cnt) return ENC_EUC;
        return ENC_BINARY;
    endfunction

    // Watch both channels: check results, then predict from accepted items
    always @(posedge i_clk) begin : monitor
        t_file_stats nxt;
        logic [3:0]  want;
        if (!i_rst_n) begin
            stats = '0;
            verdict_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected encoding, expected none, got %0d",
                             $time, i_encoding);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== i_encoding) begin
                        $display("%0t: encoding mismatch, expected %0d, got %0d",
                                 $time, want, i_encoding);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                nxt = stats;
                if (i_has_byte) nxt = fold_byte(nxt, i_data_byte);
                if (i_last) begin
                    verdict_q.push_back(judge_file(nxt));
                    nxt = '0;
                end
                stats = nxt;
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ted_pkg::*;

    // Narrow counters so that saturation is reachable
    localparam int CNT_W = 8;

    // Kinds of generated file
    localparam int FILE_ASCII    = 0;
    localparam int FILE_JIS      = 1;
    localparam int FILE_UTF8     = 2;
    localparam int FILE_SJIS     = 3;
    localparam int FILE_EUC      = 4;
    localparam int FILE_UCS2LE   = 5;
    localparam int FILE_UCS2BE   = 6;
    localparam int FILE_BINARY   = 7;
    localparam int FILE_EUC_LONG = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       has_byte = 1'b0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] encoding;
    int         fail_count;
    int         pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;

    text_encoding_detector_unit #(.COUNT_BITS(CNT_W)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_data_byte (data_byte),
        .i_has_byte  (has_byte),
        .i_last      (last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_encoding  (encoding)
    );

    ted_verdict_checker #(.COUNT_BITS(CNT_W)) verdict_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_data_byte  (data_byte),
        .i_has_byte   (has_byte),
        .i_last       (last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_encoding   (encoding),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

    // Offer one item, idling at random first, and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic h, input logic l);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= h;
        last      <= l;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
    endtask

    // Build a file of the given kind, damage it now and then, and send it
    task automatic send_file(input int kind, input int units);
        logic [7:0] body[$];
        logic [7:0] b;
        int         k;
        int         n;
        int         r;
        int         pos;
        logic       bare_end;
        body.delete();
        for (k = 0; k < units; k++) begin
            case (kind)
                FILE_ASCII: begin
                    body.push_back(8'($urandom_range(1, 127)));
                end
                FILE_JIS: begin
                    if ($urandom_range(2) == 0) begin
                        body.push_back(BYTE_ESC);
                        body.push_back(8'h24);
                        body.push_back(8'h42);
                    end else begin
                        body.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    end
                end
                FILE_UTF8: begin
                    r = $urandom_range(9);
                    n = (r < 4) ? 1 : (r < 7) ? 2 : (r == 7) ? 3 : (r == 8) ? 4
                                                            : $urandom_range(5, 6);
                    case (n)
                        1: b = 8'($urandom_range(0, 8'h7F));
                        2: b = 8'($urandom_range(8'hC0, 8'hDF));
                        3: b = 8'($urandom_range(8'hE0, 8'hEF));
                        4: b = 8'($urandom_range(8'hF0, 8'hF7));
                        5: b = 8'($urandom_range(8'hF8, 8'hFB));
                        default: b = 8'($urandom_range(8'hFC, 8'hFD));
                    endcase
                    body.push_back(b);
                    for (r = 1; r < n; r++)
                        body.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                FILE_SJIS: begin
                    body.push_back(8'($urandom_range(SJIS_LO, SJIS_HI)));
                    body.push_back(8'($urandom_range(8'h40, 8'hFC)));
                end
                FILE_EUC: begin
                    body.push_back(8'($urandom_range(EUC_LO, 8'hFE)));
                    body.push_back(8'($urandom_range(EUC_LO, 8'hFE)));
                end
                FILE_UCS2LE: begin
                    if (k == 0 && $urandom_range(1)) begin
                        body.push_back(BYTE_FF);
                        body.push_back(BYTE_FE);
                    end
                    body.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    body.push_back(BYTE_NUL);
                end
                FILE_UCS2BE: begin
                    if (k == 0 && $urandom_range(1)) begin
                        body.push_back(BYTE_FE);
                        body.push_back(BYTE_FF);
                    end
                    body.push_back(BYTE_NUL);
                    body.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                FILE_EUC_LONG: begin
                    if ($urandom_range(3) != 0)
                        body.push_back(8'($urandom_range(EUC_LO, EUC_HI)));
                    else
                        body.push_back(8'($urandom_range(8'h80, 8'hFF)));
                end
                default: begin
                    body.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end

        // Noise: corrupt one byte, or break the length
        if (body.size() > 0 && $urandom_range(99) < 15)
            body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(99) < 10) body.push_back(8'($urandom_range(0, 255)));

        // End on the last byte or on a bare end marker
        bare_end = (body.size() == 0) || ($urandom_range(1) == 1);
        for (pos = 0; pos < body.size(); pos++) begin
            if ($urandom_range(99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(body[pos], 1'b1, !bare_end && (pos == body.size() - 1));
        end
        if (bare_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Receiver: random stalls, plus one long hold-off to fill the block
    initial begin : receiver
        int cyc;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= 200 && cyc < 400) out_ready <= 1'b0;
            else out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : stimulus
        int  kind;
        bit  long_done;
        long_done = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files
        send_item(8'hA5, 1'b0, 1'b1);               // empty file
        send_item(BYTE_FF, 1'b1, 1'b0);             // little-endian mark
        send_item(BYTE_FE, 1'b1, 1'b1);
        send_item(BYTE_FE, 1'b1, 1'b0);             // big-endian mark
        send_item(BYTE_FF, 1'b1, 1'b1);
        send_item(BYTE_FF, 1'b1, 1'b0);             // mark ignored at odd length
        send_item(BYTE_FE, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b1);
        send_item(BYTE_ESC, 1'b1, 1'b0);            // escape with a bare step inside
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h41, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b1);               // plain ASCII
        send_item(BYTE_NUL, 1'b1, 1'b1);            // lone NUL
        send_item(8'hC3, 1'b1, 1'b0);               // two-byte UTF-8, bare end
        send_item(8'hA9, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hF8, 1'b1, 1'b0);               // five-byte UTF-8 form
        repeat (3) send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hBF, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);               // stray continuation byte

        // Random files in three idling phases
        send_idle_pct = 13;
        recv_idle_pct = 52;
        while (items_sent < 550) begin
            if (items_sent >= 220 && !long_done) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                send_file(FILE_EUC_LONG, $urandom_range(260, 280));
                long_done = 1'b1;
            end else begin
                if (items_sent >= 100 && !long_done) begin
                    send_idle_pct = 52;
                    recv_idle_pct = 13;
                end
                kind = $urandom_range(FILE_ASCII, FILE_BINARY);
                if (kind == FILE_UCS2LE || kind == FILE_UCS2BE)
                    send_file(kind, $urandom_range(0, 14));
                else
                    send_file(kind, $urandom_range(0, 6));
            end
        end

        // Drain and give the verdict
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
